>>> hw/rtl/afc_pkg.sv
// Shared types and constants for the box-versus-frustum classifier.
// No dependencies; used by afc_plane_unit and aabb_frustum_classifier_top.
package afc_pkg;

  // plane register layout: nx, ny, nz (Q2.14) then distance, 16 bits each
  localparam int PLANE_W     = 64;
  localparam int FIELD_W     = 16;
  localparam int NX_LSB      = 0;
  localparam int NY_LSB      = 16;
  localparam int NZ_LSB      = 32;
  localparam int DIST_LSB    = 48;
  localparam int NORM_FRAC   = 14;
  localparam int CORNERS     = 8;

  // register map
  localparam int PLANE_REGS  = 6;
  localparam int CFG_IDX_W   = 3;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_LAST = CFG_IDX_W'(PLANE_REGS - 1);

  typedef enum logic [1:0] {
    VIS_OUTSIDE = 2'd0,
    VIS_PARTIAL = 2'd1,
    VIS_INSIDE  = 2'd2
  } vis_class_t;

  // load enables for the three datapath stages inside a plane unit
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } stage_en_t;

endpackage

>>> hw/rtl/afc_plane_unit.sv
// One plane's datapath: products, partial sums and corner sign bits, three stages.
// Depends on afc_pkg for field layout and the stage enable struct.
module afc_plane_unit #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  afc_pkg::stage_en_t            en,
  input  logic [afc_pkg::PLANE_W-1:0]   plane,
  input  logic signed [COORD_WIDTH-1:0] lo [3],
  input  logic signed [COORD_WIDTH-1:0] hi [3],
  output logic [afc_pkg::CORNERS-1:0]   neg_r
);

  localparam int PW = COORD_WIDTH + afc_pkg::FIELD_W;
  localparam int DW = afc_pkg::FIELD_W + afc_pkg::NORM_FRAC;
  localparam int SW = ((PW > DW) ? PW : DW) + 2;

  logic signed [afc_pkg::FIELD_W-1:0] nx, ny, nz, ofs;

  assign nx  = plane[afc_pkg::NX_LSB   +: afc_pkg::FIELD_W];
  assign ny  = plane[afc_pkg::NY_LSB   +: afc_pkg::FIELD_W];
  assign nz  = plane[afc_pkg::NZ_LSB   +: afc_pkg::FIELD_W];
  assign ofs = plane[afc_pkg::DIST_LSB +: afc_pkg::FIELD_W];

  // stage 1: one product per axis and per face of the box
  logic signed [PW-1:0] px_r [2], py_r [2], pz_r [2];
  logic signed [PW-1:0] px_nxt [2], py_nxt [2], pz_nxt [2];
  logic signed [SW-1:0] dsh_r, dsh_nxt;

  always_comb begin
    px_nxt[0] = PW'(nx) * PW'(lo[0]);
    px_nxt[1] = PW'(nx) * PW'(hi[0]);
    py_nxt[0] = PW'(ny) * PW'(lo[1]);
    py_nxt[1] = PW'(ny) * PW'(hi[1]);
    pz_nxt[0] = PW'(nz) * PW'(lo[2]);
    pz_nxt[1] = PW'(nz) * PW'(hi[2]);
    dsh_nxt   = SW'(ofs) <<< afc_pkg::NORM_FRAC;
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      px_r  <= px_nxt;
      py_r  <= py_nxt;
      pz_r  <= pz_nxt;
      dsh_r <= dsh_nxt;
    end
  end

  // stage 2: x+y for the four xy corners, z+d for the two z faces
  logic signed [SW-1:0] pxy_r [4], pxy_nxt [4];
  logic signed [SW-1:0] pzd_r [2], pzd_nxt [2];

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      pxy_nxt[j] = SW'(px_r[j % 2]) + SW'(py_r[j / 2]);
    end
    for (int k = 0; k < 2; k++) begin
      pzd_nxt[k] = SW'(pz_r[k]) + dsh_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      pxy_r <= pxy_nxt;
      pzd_r <= pzd_nxt;
    end
  end

  // stage 3: full plane value per corner, keep only the sign
  logic signed [SW-1:0] dot [afc_pkg::CORNERS];
  logic [afc_pkg::CORNERS-1:0] neg_nxt;

  always_comb begin
    for (int c = 0; c < afc_pkg::CORNERS; c++) begin
      dot[c]     = pxy_r[c % 4] + pzd_r[c / 4];
      neg_nxt[c] = dot[c][SW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      neg_r <= neg_nxt;
    end
  end

endmodule

>>> hw/rtl/aabb_frustum_classifier_top.sv
// Box-versus-frustum classifier, top level: plane registers, pipeline control, class stage.
// Depends on afc_pkg and afc_plane_unit.
//
// Classifies one axis-aligned box per request against PLANE_COUNT planes and returns
// outside, partial or fully inside. It takes a box every cycle unless full and stalled;
// it has four register stages (products, two adder stages, class register). Each plane
// has its own unit of six multipliers, so throughput is set only by downstream
// back-pressure; a stall holds occupied stages that cannot move on and bubbles are
// squeezed out. Plane registers must be written only while no box is in flight; this
// is not enforced. Planes past the sixth read as zero and never mark a corner negative.
module aabb_frustum_classifier_top #(
  parameter int PLANE_COUNT = 6,
  parameter int COORD_WIDTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // box requests
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [COORD_WIDTH-1:0]        in_min_x,
  input  logic signed [COORD_WIDTH-1:0]        in_min_y,
  input  logic signed [COORD_WIDTH-1:0]        in_min_z,
  input  logic signed [COORD_WIDTH-1:0]        in_max_x,
  input  logic signed [COORD_WIDTH-1:0]        in_max_y,
  input  logic signed [COORD_WIDTH-1:0]        in_max_z,
  // results
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [1:0]                           out_visibility_class,
  // configuration
  input  logic                                 cfg_wr_en,
  input  logic [afc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [afc_pkg::PLANE_W-1:0]          cfg_data
);

  // plane registers
  logic [afc_pkg::PLANE_W-1:0] plane_r [afc_pkg::PLANE_REGS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < afc_pkg::PLANE_REGS; i++) begin
        plane_r[i] <= '0;
      end
    end else if (cfg_wr_en && cfg_index <= afc_pkg::REG_PLANE_LAST) begin
      plane_r[cfg_index] <= cfg_data;
    end
  end

  // pipeline control: each stage loads when empty or when the next one moves
  logic v1_r, v2_r, v3_r, out_valid_r;
  logic adv1, adv2, adv3, adv4;
  afc_pkg::stage_en_t en;

  assign adv4     = !out_valid_r || out_ready;
  assign adv3     = !v3_r || adv4;
  assign adv2     = !v2_r || adv3;
  assign adv1     = !v1_r || adv2;
  assign in_ready = adv1;
  assign en       = '{s1: adv1, s2: adv2, s3: adv3};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv1) v1_r        <= in_valid;
      if (adv2) v2_r        <= v1_r;
      if (adv3) v3_r        <= v2_r;
      if (adv4) out_valid_r <= v3_r;
    end
  end

  logic signed [COORD_WIDTH-1:0] lo [3], hi [3];

  assign lo[0] = in_min_x;
  assign lo[1] = in_min_y;
  assign lo[2] = in_min_z;
  assign hi[0] = in_max_x;
  assign hi[1] = in_max_y;
  assign hi[2] = in_max_z;

  logic [afc_pkg::CORNERS-1:0] neg [PLANE_COUNT];

  for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_plane
    logic [afc_pkg::PLANE_W-1:0] plane_word;
    if (p < afc_pkg::PLANE_REGS) begin : g_reg
      assign plane_word = plane_r[p];
    end else begin : g_zero
      assign plane_word = '0;
    end
    afc_plane_unit #(
      .COORD_WIDTH (COORD_WIDTH)
    ) u_plane (
      .clk   (clk),
      .en    (en),
      .plane (plane_word),
      .lo    (lo),
      .hi    (hi),
      .neg_r (neg[p])
    );
  end

  // class stage
  afc_pkg::vis_class_t vis_r, vis_nxt;
  logic culled, any_neg;

  always_comb begin
    culled  = 1'b0;
    any_neg = 1'b0;
    for (int p = 0; p < PLANE_COUNT; p++) begin
      culled  = culled  | (&neg[p]);
      any_neg = any_neg | (|neg[p]);
    end
    if (culled) begin
      vis_nxt = afc_pkg::VIS_OUTSIDE;
    end else if (!any_neg) begin
      vis_nxt = afc_pkg::VIS_INSIDE;
    end else begin
      vis_nxt = afc_pkg::VIS_PARTIAL;
    end
  end

  always_ff @(posedge clk) begin
    if (adv4) begin
      vis_r <= vis_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_visibility_class = vis_r;

  // a blocked input means every stage holds a request
  a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (v1_r && v2_r && v3_r && out_valid_r))
    else $error("input blocked with a bubble in the pipeline");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> v1_r)
    else $error("accepted request did not enter stage one");

  a_last_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && adv4) |=> out_valid_r)
    else $error("request lost between sign stage and output");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(vis_r)))
    else $error("stalled result changed");

endmodule

>>> verif/aabb_frustum_classifier_top_test.sv
// Testbench for aabb_frustum_classifier_top: box requests against programmed frustum planes.
// Depends on afc_pkg and the classifier RTL; classes are predicted locally and checked in order.
module aabb_frustum_classifier_top_test;
  import afc_pkg::*;

  localparam int PLANE_COUNT = 6;
  localparam int COORD_W     = 16;
  localparam int PIPE_LAT    = 4;
  localparam int CYCLE_LIMIT = 200000;
  localparam int IDX_SPAN    = 1 << CFG_IDX_W;

  typedef struct packed {
    logic signed [COORD_W-1:0] min_x;
    logic signed [COORD_W-1:0] min_y;
    logic signed [COORD_W-1:0] min_z;
    logic signed [COORD_W-1:0] max_x;
    logic signed [COORD_W-1:0] max_y;
    logic signed [COORD_W-1:0] max_z;
  } box_t;

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_ready;
  logic signed [COORD_W-1:0]   in_min_x, in_min_y, in_min_z;
  logic signed [COORD_W-1:0]   in_max_x, in_max_y, in_max_z;
  logic                        out_valid;
  logic                        out_ready;
  logic [1:0]                  out_visibility_class;
  logic                        cfg_wr_en;
  logic [CFG_IDX_W-1:0]        cfg_index;
  logic [PLANE_W-1:0]          cfg_data;

  // local copy of the plane registers; slots past the last register stay zero
  logic [PLANE_W-1:0] plane_q [CORNERS];
  vis_class_t         pending_class [$];
  int                 error_count;
  int                 cycle_count;
  bit                 gaps_on;
  bit                 stalls_on;
  int                 stall_left;

  aabb_frustum_classifier_top #(
    .PLANE_COUNT(PLANE_COUNT),
    .COORD_WIDTH(COORD_W)
  ) i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_min_x            (in_min_x),
    .in_min_y            (in_min_y),
    .in_min_z            (in_min_z),
    .in_max_x            (in_max_x),
    .in_max_y            (in_max_y),
    .in_max_z            (in_max_z),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_visibility_class(out_visibility_class),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic vis_class_t classify_box(box_t b);
    logic signed [FIELD_W-1:0] nx, ny, nz, ofs;
    logic signed [COORD_W-1:0] x, y, z;
    longint                    dot;
    int                        negs;
    bit                        any_neg;
    bit                        culled;
    any_neg = 1'b0;
    culled  = 1'b0;
    for (int p = 0; p < PLANE_COUNT; p++) begin
      nx   = plane_q[p][NX_LSB +: FIELD_W];
      ny   = plane_q[p][NY_LSB +: FIELD_W];
      nz   = plane_q[p][NZ_LSB +: FIELD_W];
      ofs  = plane_q[p][DIST_LSB +: FIELD_W];
      negs = 0;
      for (int c = 0; c < CORNERS; c++) begin
        x   = c[0] ? b.max_x : b.min_x;
        y   = c[1] ? b.max_y : b.min_y;
        z   = c[2] ? b.max_z : b.min_z;
        dot = longint'(nx) * longint'(x) + longint'(ny) * longint'(y)
            + longint'(nz) * longint'(z) + (longint'(ofs) <<< NORM_FRAC);
        if (dot < 0) negs++;
      end
      if (negs > 0) any_neg = 1'b1;
      if (negs == CORNERS) culled = 1'b1;
    end
    if (culled) return VIS_OUTSIDE;
    if (!any_neg) return VIS_INSIDE;
    return VIS_PARTIAL;
  endfunction

  function automatic logic [PLANE_W-1:0] make_plane(int nx, int ny, int nz, int ofs);
    return {16'(ofs), 16'(nz), 16'(ny), 16'(nx)};
  endfunction

  function automatic logic signed [COORD_W-1:0] clamp_coord(int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return COORD_W'(v);
  endfunction

  function automatic box_t make_box(int x0, int y0, int z0, int x1, int y1, int z1);
    box_t b;
    b.min_x = clamp_coord(x0);
    b.min_y = clamp_coord(y0);
    b.min_z = clamp_coord(z0);
    b.max_x = clamp_coord(x1);
    b.max_y = clamp_coord(y1);
    b.max_z = clamp_coord(z1);
    return b;
  endfunction

  // one face of a rough cube around the origin, normal tilted a little
  function automatic logic [PLANE_W-1:0] rand_face(int axis, bit neg_side);
    int comp [3];
    int half;
    for (int k = 0; k < 3; k++) comp[k] = int'($urandom_range(0, 4000)) - 2000;
    comp[axis] = 16384 + int'($urandom_range(0, 2000)) - 1000;
    if (neg_side) comp[axis] = -comp[axis];
    half = $urandom_range(2000, 20000);
    return make_plane(comp[0], comp[1], comp[2], half);
  endfunction

  function automatic box_t rand_box();
    int   ctr [3];
    int   ext [3];
    box_t b;
    if ($urandom_range(0, 9) == 0) begin
      b = {$urandom, $urandom, $urandom};
      return b;
    end
    for (int k = 0; k < 3; k++) begin
      ctr[k] = int'($urandom_range(0, 50000)) - 25000;
      ext[k] = $urandom_range(0, 8000);
    end
    b = make_box(ctr[0] - ext[0], ctr[1] - ext[1], ctr[2] - ext[2],
                 ctr[0] + ext[0], ctr[1] + ext[1], ctr[2] + ext[2]);
    // occasionally swap one axis so min exceeds max
    if ($urandom_range(0, 19) == 0) begin
      b.min_y = b.max_y;
      b.max_y = clamp_coord(ctr[1] - ext[1] - 1);
    end
    return b;
  endfunction

  // result side: random stall bursts on out_ready
  initial begin
    out_ready  <= 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (stalls_on && $urandom_range(0, 4) == 0) begin
        out_ready  <= 1'b0;
        stall_left = $urandom_range(0, 2);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_class.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %0d", $time,
                 out_visibility_class);
        error_count++;
      end else begin
        vis_class_t want;
        want = pending_class.pop_front();
        if (out_visibility_class !== want) begin
          $display("%0t: visibility_class mismatch: expected %0d, actual %0d", $time,
                   want, out_visibility_class);
          error_count++;
        end
      end
    end
  end

  // one box request; valid is left high so back-to-back requests need no extra edge
  task automatic send_box(box_t b);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_min_x <= b.min_x;
    in_min_y <= b.min_y;
    in_min_z <= b.min_z;
    in_max_x <= b.max_x;
    in_max_y <= b.max_y;
    in_max_z <= b.max_z;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_class = {pending_class, classify_box(b)};
  endtask

  // hold off requests until every result is back and the pipe is empty
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_class.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 2) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [PLANE_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    if (idx < PLANE_REGS) plane_q[idx] = data;
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_frustum();
    drain();
    for (int a = 0; a < 3; a++) begin
      write_reg(CFG_IDX_W'(2 * a), rand_face(a, 1'b0));
      write_reg(CFG_IDX_W'(2 * a + 1), rand_face(a, 1'b1));
    end
  endtask

  task automatic load_all_planes(logic [PLANE_W-1:0] data);
    drain();
    for (int p = 0; p < PLANE_REGS; p++) write_reg(CFG_IDX_W'(p), data);
  endtask

  // planes at reset are zero: everything is fully inside
  task automatic test_reset_planes();
    send_box(make_box(0, 0, 0, 100, 100, 100));
    send_box(make_box(-32768, -32768, -32768, 32767, 32767, 32767));
    send_box(make_box(32767, 32767, 32767, -32768, -32768, -32768));
  endtask

  task automatic test_directed();
    logic [PLANE_W-1:0] cull_all;
    cull_all = make_plane(0, 0, 0, -1);
    drain();
    // half-space x >= -1000
    write_reg(REG_PLANE_LAST - 3'd5, make_plane(16384, 0, 0, 1000));
    send_box(make_box(0, 0, 0, 100, 100, 100));
    send_box(make_box(-5000, 0, 0, -1001, 10, 10));
    send_box(make_box(-2000, 0, 0, 2000, 0, 0));
    // corner exactly on the plane is not negative
    send_box(make_box(-1000, 0, 0, 10, 5, 5));
    send_box(make_box(-1001, 7, 7, -1001, 7, 7));
    // swapped min and max on x
    send_box(make_box(500, 0, 0, -2000, 20, 20));
    send_box(make_box(-32768, -32768, -32768, 32767, 32767, 32767));
    send_box(make_box(-32768, -32768, -32768, -32768, -32768, -32768));
    send_box(make_box(32767, 32767, 32767, 32767, 32767, 32767));
    // full-scale normal and distance
    drain();
    write_reg(REG_PLANE_LAST - 3'd4, make_plane(-32768, 32767, -32768, -32768));
    send_box(make_box(-32768, -32768, -32768, 32767, 32767, 32767));
    send_box(make_box(0, 0, 0, 0, 0, 0));
    send_box(make_box(-32768, 32767, -32768, -32768, 32767, -32768));
    send_box(make_box(-1000, 32767, -32768, 32767, 32767, -32768));
    // writes past the last plane must not take effect
    drain();
    for (int i = PLANE_REGS; i < IDX_SPAN; i++) write_reg(CFG_IDX_W'(i), cull_all);
    send_box(make_box(-1000, 32767, -32768, 32767, 32767, -32768));
    send_box(make_box(0, 0, 0, 100, 100, 100));
    // zero normal with negative distance culls every box
    drain();
    write_reg(REG_PLANE_LAST, cull_all);
    send_box(make_box(0, 0, 0, 100, 100, 100));
    send_box(make_box(32767, 32767, 32767, 32767, 32767, 32767));
    load_all_planes('0);
    send_box(make_box(-32768, 0, 0, 32767, 0, 0));
  endtask

  task automatic test_random_frustum(int settings, int per_setting);
    for (int s = 0; s < settings; s++) begin
      load_frustum();
      for (int n = 0; n < per_setting; n++) begin
        send_box(rand_box());
        if (n == per_setting / 2 && s == 0) drain();
      end
    end
  endtask

  task automatic test_random_planes(int settings, int per_setting);
    for (int s = 0; s < settings; s++) begin
      drain();
      for (int p = 0; p < PLANE_REGS; p++) write_reg(CFG_IDX_W'(p), {$urandom, $urandom});
      for (int n = 0; n < per_setting; n++) send_box(rand_box());
    end
  endtask

  task automatic test_extreme_planes();
    load_all_planes(64'h7fff_7fff_7fff_7fff);
    repeat (10) send_box(rand_box());
    send_box(make_box(-32768, -32768, -32768, -32768, -32768, -32768));
    load_all_planes(64'h8000_8000_8000_8000);
    repeat (10) send_box(rand_box());
    send_box(make_box(32767, 32767, 32767, 32767, 32767, 32767));
  endtask

  // last stretch at full rate, no gaps and no stalls
  task automatic test_full_rate();
    load_frustum();
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    repeat (100) send_box(rand_box());
  endtask

  initial begin
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_min_x    <= '0;
    in_min_y    <= '0;
    in_min_z    <= '0;
    in_max_x    <= '0;
    in_max_y    <= '0;
    in_max_z    <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_index   <= '0;
    cfg_data    <= '0;
    error_count = 0;
    cycle_count = 0;
    gaps_on     = 1'b1;
    stalls_on   = 1'b1;
    for (int p = 0; p < CORNERS; p++) plane_q[p] = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_planes();
    test_directed();
    test_random_frustum(4, 100);
    test_random_planes(3, 40);
    test_extreme_planes();
    test_full_rate();

    drain();
    repeat (PIPE_LAT * 2) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
